FILE: src/ppe_pkg.sv
// Shared constants and types for the palette pixel expander.
// Depends on nothing; every other file in src imports it.
package ppe_pkg;

  // Source pixel width and output color width.
  localparam int SRC_BPP = 4;
  localparam int OUT_BPP = 16;

  localparam int IDX_W         = SRC_BPP;
  localparam int TABLE_DEPTH   = 1 << SRC_BPP;
  localparam int COLOR_W       = 16;
  localparam int WORD_W        = 32;
  localparam int PIX_PER_IN    = WORD_W / SRC_BPP;
  localparam int LANE_BITS     = (OUT_BPP == 16) ? 16 : 8;
  localparam int LANES         = WORD_W / LANE_BITS;
  localparam int NOUT_RAW      = (PIX_PER_IN + LANES - 1) / LANES;
  localparam int NOUT          = (NOUT_RAW > 16) ? 16 : ((NOUT_RAW == 0) ? 1 : NOUT_RAW);
  localparam int KW            = (NOUT > 1) ? $clog2(NOUT) : 1;
  localparam int STEP_BITS     = LANES * SRC_BPP;
  localparam int WIDE_W        = WORD_W + STEP_BITS;
  localparam bit COPY_MODE     = (SRC_BPP == 8) && (LANE_BITS == 8);

  // Input item kinds carried in tuser.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_EXPAND = 1'b1;

  // One read step handed from the sequencer to the merge stage.
  typedef struct packed {
    logic                vld;
    logic                last;
    logic [LANES-1:0]    mask;
    logic [WORD_W-1:0]   word;
  } ppe_issue_t;

  // Palette write broadcast to every lane copy.
  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic [COLOR_W-1:0]  color;
  } ppe_wr_t;

  typedef logic [LANES-1:0][LANE_BITS-1:0] ppe_lane_data_t;

endpackage

FILE: src/ppe_lane.sv
// One lookup lane: a private copy of the palette with a registered read.
// Depends on ppe_pkg.
module ppe_lane
  import ppe_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  ppe_wr_t              wr,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic [LANE_BITS-1:0] rd_data
);

  logic [COLOR_W-1:0]   mem [TABLE_DEPTH];
  logic [LANE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.color;
    end
    if (en) begin
      rd_data_r <= mem[rd_idx][LANE_BITS-1:0];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/ppe_seq.sv
// Input sequencer: accepts items, applies palette writes and steps through
// the output words of each expand item. Depends on ppe_pkg.
module ppe_seq
  import ppe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [55:0]             in_tdata,
  input  logic [0:0]              in_tuser,
  input  logic                    en,
  output ppe_issue_t              issue,
  output ppe_wr_t                 wr,
  output logic [LANES-1:0][IDX_W-1:0] rd_idx
);

  logic                busy_r;
  logic                op_wr_r;
  logic [WORD_W-1:0]   word_r;
  logic [WORD_W-1:0]   orig_r;
  logic [KW-1:0]       k_r;
  logic [IDX_W-1:0]    widx_r;
  logic [COLOR_W-1:0]  wcolor_r;

  logic                step;
  logic                last_step;
  logic                accept;
  logic [WIDE_W-1:0]   wide;

  assign step      = busy_r && en;
  assign last_step = op_wr_r || COPY_MODE || (k_r == KW'(NOUT - 1));
  assign in_tready = !busy_r || (step && last_step);
  assign accept    = in_tvalid && in_tready;
  assign wide      = {{STEP_BITS{1'b0}}, word_r};

  always_comb begin
    int p;
    issue.vld  = busy_r && !op_wr_r;
    issue.last = last_step;
    issue.word = orig_r;
    for (int l = 0; l < LANES; l++) begin
      p = int'(k_r) * LANES + l;
      issue.mask[l] = (p < PIX_PER_IN);
      rd_idx[l]     = wide[l*SRC_BPP +: SRC_BPP];
    end
    wr.en    = step && op_wr_r;
    wr.idx   = widx_r;
    wr.color = wcolor_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (step && last_step) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_wr_r  <= (in_tuser[0] == FUNC_WRITE);
      widx_r   <= in_tdata[IDX_W-1:0];
      wcolor_r <= in_tdata[23:8];
      word_r   <= in_tdata[55:24];
      orig_r   <= in_tdata[55:24];
      k_r      <= '0;
    end else if (step) begin
      word_r <= WORD_W'(wide >> STEP_BITS);
      k_r    <= k_r + KW'(1);
    end
  end

endmodule

FILE: src/ppe_merge.sv
// Merge stage: lines up the step control with the lane read data, packs the
// lanes into one output word and holds it in the output register.
// Depends on ppe_pkg.
module ppe_merge
  import ppe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ppe_issue_t          issue,
  input  ppe_lane_data_t      lane_data,
  output logic                en,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [WORD_W-1:0]   out_tdata,
  output logic                out_tlast
);

  ppe_issue_t          s1_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_data_r;
  logic                out_last_r;
  logic [WORD_W-1:0]   packed_nxt;

  assign en = !out_valid_r || out_tready;

  always_comb begin
    packed_nxt = '0;
    for (int l = 0; l < LANES; l++) begin
      packed_nxt[l*LANE_BITS +: LANE_BITS] = s1_r.mask[l] ? lane_data[l] : '0;
    end
    if (COPY_MODE) begin
      packed_nxt = s1_r.word;
    end
  end

  // Valid bits are reset; the data fields only follow them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_r.vld    <= issue.vld;
      out_valid_r <= s1_r.vld;
    end
    if (en) begin
      s1_r.last  <= issue.last;
      s1_r.mask  <= issue.mask;
      s1_r.word  <= issue.word;
      out_data_r <= packed_nxt;
      out_last_r <= s1_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: src/palette_pixel_expander.sv
// Top level of the palette pixel expander: sequencer, lookup lanes, merge.
// Depends on ppe_pkg, ppe_seq, ppe_lane and ppe_merge.
//
// The block turns packed framebuffer words of indexed pixels into packed
// colors. An input transfer with tuser 1 carries a 32-bit word of 4-bit
// indices, first pixel in the lowest bits; each index is looked up in a
// 16-entry, 16-bit palette and the colors leave as 32-bit words of two
// pixels, first pixel in the low half, so one input word gives four output
// transfers, the last one flagged by out_tlast. An input transfer with tuser
// 0 writes one palette entry (index masked to 4 bits) and gives no output;
// it takes effect for every expand transfer that follows it. The sequencer
// issues one output word per cycle to the lanes while the output does not
// stall, so an expand item occupies it for four steps and a palette write
// for one; the next item is taken in the cycle its predecessor issues its
// final word, so the output runs at one word per cycle when out_tready
// stays high and expand items arrive back to back. The first output word
// passes the item, lane read, merge step and output registers. Palette
// entries are not cleared by reset: read only entries that were written.
module palette_pixel_expander
  import ppe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] entry_index, [23:8] entry_color, [55:24] packed_pixels
  input  logic [55:0] in_tdata,
  // [0] func
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] out_word
  output logic [31:0] out_tdata,
  output logic        out_tlast
);

  ppe_issue_t                  issue;
  ppe_wr_t                     wr;
  logic [LANES-1:0][IDX_W-1:0] rd_idx;
  ppe_lane_data_t              lane_data;
  logic                        en;

  ppe_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .en        (en),
    .issue     (issue),
    .wr        (wr),
    .rd_idx    (rd_idx)
  );

  // Each lane keeps its own palette copy so all lanes read in the same cycle.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    ppe_lane u_lane (
      .clk     (clk),
      .en      (en),
      .wr      (wr),
      .rd_idx  (rd_idx[l]),
      .rd_data (lane_data[l])
    );
  end

  ppe_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .lane_data  (lane_data),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
